>>> hdl/scac_pkg.sv
// Shared types, character codes and constants for the serial command actuator controller.
package scac_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 48;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_S       = 8'h53;

    localparam logic [7:0]  DUTY_MAX  = 8'hFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAN_HOME  = 8'd90;
    localparam logic [7:0]  TILT_HOME = 8'd0;
    localparam logic [7:0]  ELAPSED_MAX = 8'hFF;

    // register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_UPPER    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_LOWER    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_UPPER   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_LOWER   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNT_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRE_PULSE   = 3'd5;

    localparam logic [7:0]  RST_PAN_UPPER    = 8'd175;
    localparam logic [7:0]  RST_PAN_LOWER    = 8'd40;
    localparam logic [7:0]  RST_TILT_UPPER   = 8'd40;
    localparam logic [7:0]  RST_TILT_LOWER   = 8'd0;
    localparam logic [7:0]  RST_MOUNT_PERIOD = 8'd20;
    localparam logic [15:0] RST_FIRE_PULSE   = 16'd250;

    typedef enum logic [1:0] {
        PH_CODE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_parse_phase;

    typedef enum logic [1:0] {
        BR_OFF = 2'd0,
        BR_FWD = 2'd1,
        BR_REV = 2'd2
    } t_bridge;

    typedef enum logic [2:0] {
        MD_UP    = 3'd0,
        MD_DOWN  = 3'd1,
        MD_LEFT  = 3'd2,
        MD_RIGHT = 3'd3,
        MD_STOP  = 3'd4
    } t_mount_dir;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_LEFT   = 3'd1,
        CMD_RIGHT  = 3'd2,
        CMD_FIRE   = 3'd3,
        CMD_CHARGE = 3'd4,
        CMD_MOUNT  = 3'd5,
        CMD_LOAD   = 3'd6
    } t_cmd_kind;

    // decoded command, value already reduced to what each code needs
    typedef struct packed {
        t_cmd_kind   kind;
        t_bridge     drive_dir;
        logic [7:0]  drive_duty;
        logic [31:0] charge_limit;
        t_mount_dir  mount_dir;
        logic        load_zero;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  pan_upper;
        logic [7:0]  pan_lower;
        logic [7:0]  tilt_upper;
        logic [7:0]  tilt_lower;
        logic [7:0]  mount_period;
        logic [15:0] fire_pulse;
    } t_cfg;

    typedef struct packed {
        logic       fired_ack;
        logic       charge_ack;
        logic       charged_ack;
        t_bridge    left_dir;
        logic [7:0] left_duty;
        t_bridge    right_dir;
        logic [7:0] right_duty;
        logic       pump_on;
        logic       solenoid_open;
        logic       servos_attached;
        logic [7:0] pan_angle;
        logic [7:0] tilt_angle;
    } t_status;

endpackage

>>> hdl/scac_parser.sv
// Command line parser: code letter, atol-style value, decoded command on newline.
module scac_parser
    import scac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_char_valid,
    input  logic [7:0] i_char,
    output t_cmd       o_cmd
);

    localparam int MW = VALUE_BITS;
    localparam int AW = MW + 4;
    localparam int EW = MW + 32;
    localparam logic [MW-1:0] MAG_LIM     = {1'b1, {(MW-1){1'b0}}};
    localparam logic [MW-1:0] MAG_POS_MAX = MAG_LIM - MW'(1);

    t_parse_phase  r_phase, n_phase;
    logic [7:0]    r_code, n_code;
    logic          r_neg, n_neg;
    logic [MW-1:0] r_mag, n_mag;

    logic          is_digit, is_blank, is_newline;
    logic [3:0]    digit;
    logic [AW-1:0] acc;
    logic [MW-1:0] mag_acc;
    logic          neg_eff;
    logic [MW-1:0] mag_c;
    logic [EW-1:0] mag_ext;

    assign is_newline = (i_char == CH_NEWLINE);
    assign is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_blank   = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_VTAB) ||
                        (i_char == CH_FFEED) || (i_char == CH_CR);
    assign digit      = 4'(i_char - CH_ZERO);

    // mag*10 + d, saturating at 2^(VALUE_BITS-1)
    assign acc     = AW'({r_mag, 3'b000}) + AW'({r_mag, 1'b0}) + AW'(digit);
    assign mag_acc = (acc > AW'(MAG_LIM)) ? MAG_LIM : acc[MW-1:0];

    // signed value reduced for the command decode
    assign neg_eff = r_neg && (r_mag != '0);
    assign mag_c   = (!neg_eff && (r_mag > MAG_POS_MAX)) ? MAG_POS_MAX : r_mag;
    assign mag_ext = EW'(mag_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_code  <= '0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_neg   = r_neg;
        n_mag   = r_mag;

        o_cmd.kind         = CMD_NONE;
        o_cmd.drive_dir    = (mag_c == '0) ? BR_OFF : (neg_eff ? BR_REV : BR_FWD);
        o_cmd.drive_duty   = (mag_ext > EW'(DUTY_MAX)) ? DUTY_MAX : mag_c[7:0];
        o_cmd.charge_limit = (neg_eff || (mag_ext > EW'(COUNT_MAX))) ? COUNT_MAX
                                                                       : mag_ext[31:0];
        o_cmd.mount_dir    = (!neg_eff && (mag_ext <= EW'(4))) ? t_mount_dir'(mag_c[2:0])
                                                                : MD_STOP;
        o_cmd.load_zero    = (mag_c == '0);

        if (i_char_valid) begin
            if (is_newline) begin
                if (r_phase != PH_CODE) begin
                    case (r_code)
                        CH_L:    o_cmd.kind = CMD_LEFT;
                        CH_R:    o_cmd.kind = CMD_RIGHT;
                        CH_S:    o_cmd.kind = CMD_FIRE;
                        CH_A:    o_cmd.kind = CMD_CHARGE;
                        CH_C:    o_cmd.kind = CMD_MOUNT;
                        CH_D:    o_cmd.kind = CMD_LOAD;
                        default: o_cmd.kind = CMD_NONE;
                    endcase
                end
                n_phase = PH_CODE;
                n_code  = '0;
                n_neg   = 1'b0;
                n_mag   = '0;
            end else begin
                case (r_phase)
                    PH_CODE: begin
                        n_code  = i_char;
                        n_phase = PH_SIGN;
                    end
                    PH_SIGN: begin
                        if (is_digit) begin
                            n_mag   = mag_acc;
                            n_phase = PH_DIGITS;
                        end else if (i_char == CH_PLUS) begin
                            n_phase = PH_DIGITS;
                        end else if (i_char == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else if (!is_blank) begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            n_mag = mag_acc;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/scac_actuator.sv
// Actuator state: motor bridges, pump timer, mount stepper, fire pulse, load mode.
module scac_actuator
    import scac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,
    input  t_cmd    i_cmd,
    input  t_cfg    i_cfg,
    output t_status o_status
);

    t_bridge     r_left_dir, n_left_dir, r_right_dir, n_right_dir;
    logic [7:0]  r_left_duty, n_left_duty, r_right_duty, n_right_duty;
    logic        r_pump, n_pump;
    logic [31:0] r_limit, n_limit, r_elapsed, n_elapsed;
    t_mount_dir  r_mdir, n_mdir;
    logic [7:0]  r_melapsed, n_melapsed;
    logic [7:0]  r_pan, n_pan, r_tilt, n_tilt;
    logic        r_attached, n_attached;
    logic        r_solenoid, n_solenoid;
    logic [15:0] r_fire, n_fire;
    logic        fired, charge, charged;

    logic [31:0] elapsed_inc;
    logic [7:0]  melapsed_inc;

    assign elapsed_inc  = (r_elapsed == COUNT_MAX) ? r_elapsed : r_elapsed + 32'd1;
    assign melapsed_inc = (r_melapsed == ELAPSED_MAX) ? r_melapsed : r_melapsed + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dir   <= BR_OFF;
            r_left_duty  <= '0;
            r_right_dir  <= BR_OFF;
            r_right_duty <= '0;
            r_pump       <= 1'b0;
            r_limit      <= '0;
            r_elapsed    <= '0;
            r_mdir       <= MD_STOP;
            r_melapsed   <= '0;
            r_pan        <= PAN_HOME;
            r_tilt       <= TILT_HOME;
            r_attached   <= 1'b1;
            r_solenoid   <= 1'b0;
            r_fire       <= '0;
        end else begin
            r_left_dir   <= n_left_dir;
            r_left_duty  <= n_left_duty;
            r_right_dir  <= n_right_dir;
            r_right_duty <= n_right_duty;
            r_pump       <= n_pump;
            r_limit      <= n_limit;
            r_elapsed    <= n_elapsed;
            r_mdir       <= n_mdir;
            r_melapsed   <= n_melapsed;
            r_pan        <= n_pan;
            r_tilt       <= n_tilt;
            r_attached   <= n_attached;
            r_solenoid   <= n_solenoid;
            r_fire       <= n_fire;
        end
    end

    always_comb begin
        n_left_dir   = r_left_dir;
        n_left_duty  = r_left_duty;
        n_right_dir  = r_right_dir;
        n_right_duty = r_right_duty;
        n_pump       = r_pump;
        n_limit      = r_limit;
        n_elapsed    = r_elapsed;
        n_mdir       = r_mdir;
        n_melapsed   = r_melapsed;
        n_pan        = r_pan;
        n_tilt       = r_tilt;
        n_attached   = r_attached;
        n_solenoid   = r_solenoid;
        n_fire       = r_fire;
        fired        = 1'b0;
        charge       = 1'b0;
        charged      = 1'b0;

        if (i_tick) begin
            // pump ends on the first tick past its limit
            if (r_pump) begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc > r_limit) begin
                    n_pump    = 1'b0;
                    n_limit   = '0;
                    n_elapsed = '0;
                    charged   = 1'b1;
                end
            end
            // mount: one degree per period, blocked steps still restart the count
            n_melapsed = melapsed_inc;
            if ((r_mdir != MD_STOP) && (melapsed_inc > i_cfg.mount_period)) begin
                n_melapsed = '0;
                case (r_mdir)
                    MD_UP: begin
                        if (({1'b0, r_tilt} + 9'd1) <= {1'b0, i_cfg.tilt_upper})
                            n_tilt = r_tilt + 8'd1;
                    end
                    MD_DOWN: begin
                        if (r_tilt > i_cfg.tilt_lower) n_tilt = r_tilt - 8'd1;
                    end
                    MD_LEFT: begin
                        if (({1'b0, r_pan} + 9'd1) <= {1'b0, i_cfg.pan_upper})
                            n_pan = r_pan + 8'd1;
                    end
                    MD_RIGHT: begin
                        if (r_pan > i_cfg.pan_lower) n_pan = r_pan - 8'd1;
                    end
                    default: begin
                        n_pan = r_pan;
                    end
                endcase
            end
            // fire pulse countdown
            if (r_fire != '0) begin
                n_fire = r_fire - 16'd1;
                if (r_fire == 16'd1) begin
                    n_solenoid = 1'b0;
                    fired      = 1'b1;
                end
            end
        end else begin
            case (i_cmd.kind)
                CMD_LEFT: begin
                    n_left_dir  = i_cmd.drive_dir;
                    n_left_duty = i_cmd.drive_duty;
                end
                CMD_RIGHT: begin
                    n_right_dir  = i_cmd.drive_dir;
                    n_right_duty = i_cmd.drive_duty;
                end
                CMD_FIRE: begin
                    if (i_cfg.fire_pulse == '0) begin
                        n_solenoid = 1'b0;
                        n_fire     = '0;
                        fired      = 1'b1;
                    end else begin
                        n_solenoid = 1'b1;
                        n_fire     = i_cfg.fire_pulse;
                    end
                end
                CMD_CHARGE: begin
                    n_limit   = i_cmd.charge_limit;
                    n_elapsed = '0;
                    n_pump    = 1'b1;
                    charge    = 1'b1;
                end
                CMD_MOUNT: begin
                    n_mdir = i_cmd.mount_dir;
                end
                CMD_LOAD: begin
                    if (i_cmd.load_zero) begin
                        n_attached = 1'b1;
                        n_pan      = PAN_HOME;
                        n_tilt     = TILT_HOME;
                        n_solenoid = 1'b0;
                    end else begin
                        n_attached = 1'b0;
                        n_solenoid = 1'b1;
                    end
                end
                default: begin
                    n_pump = r_pump;
                end
            endcase
        end

        o_status.fired_ack       = fired;
        o_status.charge_ack      = charge;
        o_status.charged_ack     = charged;
        o_status.left_dir        = n_left_dir;
        o_status.left_duty       = n_left_duty;
        o_status.right_dir       = n_right_dir;
        o_status.right_duty      = n_right_duty;
        o_status.pump_on         = n_pump;
        o_status.solenoid_open   = n_solenoid;
        o_status.servos_attached = n_attached;
        o_status.pan_angle       = n_pan;
        o_status.tilt_angle      = n_tilt;
    end

endmodule

>>> hdl/serial_command_actuator_controller.sv
// Top level: input register, parser and actuator pass, output register, config registers.
//
// Usage:
//   Slave stream carries one word per received character or millisecond tick:
//   s_axis_tuser is the kind (0 character, 1 tick), s_axis_tdata the character.
//   Every accepted word yields exactly one master word holding the acknowledge
//   pulses of that word and the actuator status after it.
//   Config registers are written through i_cfg_we/i_cfg_index/i_cfg_data while
//   the stream is idle; index 0..5 = pan upper/lower, tilt upper/lower,
//   mount period, fire pulse. Other indexes are dropped.
// Timing:
//   The word lands in the input register; when it advances, parse and update run
//   in one pass and load the output register.
//   Throughput is one word per cycle without a stall; the limit is the combinational
//   state update (decimal accumulate plus timer compares) between the two registers.
// Reset (i_rst_n low, synchronous): both pipeline registers empty, parser back
//   to waiting for a code letter, motors off, pump idle, solenoid closed,
//   servos attached at pan 90 / tilt 0, mount stopped, config at defaults.
// Stall: when m_axis_tready is low the output word holds; the input register
//   still takes one more word, then s_axis_tready drops until the output drains.
module serial_command_actuator_controller
    import scac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] char_byte
    input  logic                    s_axis_tuser,   // [0] operation
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [0] fired_ack, [1] charge_ack, [2] charged_ack, [4:3] left_dir,
    // [12:5] left_duty, [14:13] right_dir, [22:15] right_duty, [23] pump_on,
    // [24] solenoid_open, [25] servos_attached, [33:26] pan_angle,
    // [41:34] tilt_angle, [47:42] zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_char;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    advance;

    // a word moves through the update pass when the output slot is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_char <= s_axis_tdata;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_upper    <= RST_PAN_UPPER;
            r_cfg.pan_lower    <= RST_PAN_LOWER;
            r_cfg.tilt_upper   <= RST_TILT_UPPER;
            r_cfg.tilt_lower   <= RST_TILT_LOWER;
            r_cfg.mount_period <= RST_MOUNT_PERIOD;
            r_cfg.fire_pulse   <= RST_FIRE_PULSE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAN_UPPER:    r_cfg.pan_upper    <= i_cfg_data[7:0];
                CFG_PAN_LOWER:    r_cfg.pan_lower    <= i_cfg_data[7:0];
                CFG_TILT_UPPER:   r_cfg.tilt_upper   <= i_cfg_data[7:0];
                CFG_TILT_LOWER:   r_cfg.tilt_lower   <= i_cfg_data[7:0];
                CFG_MOUNT_PERIOD: r_cfg.mount_period <= i_cfg_data[7:0];
                CFG_FIRE_PULSE:   r_cfg.fire_pulse   <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    scac_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_valid(advance && !r_in_op),
        .i_char      (r_in_char),
        .o_cmd       (cmd)
    );

    scac_actuator u_actuator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (advance && r_in_op),
        .i_cmd   (cmd),
        .i_cfg   (r_cfg),
        .o_status(status)
    );

    // actuator state only moves on advance; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {6'd0,
                           status.tilt_angle,
                           status.pan_angle,
                           status.servos_attached,
                           status.solenoid_open,
                           status.pump_on,
                           status.right_duty,
                           status.right_dir,
                           status.left_duty,
                           status.left_dir,
                           status.charged_ack,
                           status.charge_ack,
                           status.fired_ack};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> hdl/scac_checker.sv
// Port-level checker for the serial command actuator controller, bound to the top level.
module scac_checker
    import scac_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // charge start shows the pump running in the same word
    a_charge_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[23])
        else $error("charge ack without pump on");

    // charge end shows the pump stopped
    a_charged_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[23])
        else $error("charged ack with pump still on");

    // fire end always leaves the solenoid closed
    a_fired_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[24])
        else $error("fired ack with solenoid open");

endmodule

bind serial_command_actuator_controller scac_checker u_scac_checker (.*);
